[rtl/ciaes_pkg.sv]
// Shared types, constants and table functions for the CiA 402 enable and sine trajectory block.
package ciaes_pkg;

  // Default build parameters
  localparam int unsigned DEF_TABLE_ADDR_BITS    = 10;
  localparam int unsigned DEF_SINE_FRACTION_BITS = 15;
  localparam int unsigned DEF_QUEUE_DEPTH        = 2;

  // Register widths and reset values
  localparam int unsigned AMP_W   = 20;
  localparam int unsigned HOLD_W  = 24;
  localparam int unsigned STEP_W  = 32;
  localparam int unsigned MODE_W  = 8;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  localparam logic [AMP_W-1:0]         AMP_RESET  = 20'd5000;
  localparam logic [HOLD_W-1:0]        HOLD_RESET = 24'd3000;
  localparam logic [STEP_W-1:0]        STEP_RESET = 32'd858993;
  localparam logic signed [MODE_W-1:0] MODE_RESET = 8'sd8;

  // Register map, index is paddr[3:2]
  typedef enum logic [1:0] {
    REG_AMPLITUDE = 2'd0,
    REG_HOLD      = 2'd1,
    REG_STEP      = 2'd2,
    REG_MODE      = 2'd3
  } reg_idx_e;

  // Status word masks and patterns
  localparam logic [15:0] MASK_4F   = 16'h004F;
  localparam logic [15:0] MASK_6F   = 16'h006F;
  localparam logic [15:0] PAT_SOD   = 16'h0040;
  localparam logic [15:0] PAT_RTSO  = 16'h0021;
  localparam logic [15:0] PAT_SO    = 16'h0023;
  localparam logic [15:0] PAT_OE    = 16'h0027;
  localparam logic [15:0] PAT_QS    = 16'h0007;
  localparam logic [15:0] PAT_FLT   = 16'h000F;
  localparam logic [15:0] PAT_FLTR  = 16'h0008;
  localparam logic [15:0] PAT_NRTSO = 16'h0000;

  // Control words
  localparam logic [7:0] CW_NONE      = 8'h00;
  localparam logic [7:0] CW_SHUTDOWN  = 8'h06;
  localparam logic [7:0] CW_SWITCH_ON = 8'h07;
  localparam logic [7:0] CW_ENABLE_OP = 8'h0F;
  localparam logic [7:0] CW_FAULT_RST = 8'h80;

  typedef enum logic [2:0] {
    ST_NOT_READY   = 3'd0,
    ST_DISABLED    = 3'd1,
    ST_READY       = 3'd2,
    ST_SWITCHED_ON = 3'd3,
    ST_ENABLED     = 3'd4,
    ST_QUICK_STOP  = 3'd5,
    ST_FAULT       = 3'd6,
    ST_OTHER       = 3'd7
  } drive_state_e;

  // Classified item passed from front to back
  typedef struct packed {
    logic [7:0]   cw;
    drive_state_e st;
    logic [31:0]  base;
    logic         use_sine;
  } item_t;

  // Decode the status word, first matching mask wins
  function automatic drive_state_e decode_state(input logic [15:0] sw);
    drive_state_e st;
    priority if ((sw & MASK_4F) == PAT_SOD)   st = ST_DISABLED;
    else if ((sw & MASK_6F) == PAT_RTSO)      st = ST_READY;
    else if ((sw & MASK_6F) == PAT_SO)        st = ST_SWITCHED_ON;
    else if ((sw & MASK_6F) == PAT_OE)        st = ST_ENABLED;
    else if ((sw & MASK_6F) == PAT_QS)        st = ST_QUICK_STOP;
    else if ((sw & MASK_4F) == PAT_FLT)       st = ST_FAULT;
    else if ((sw & MASK_4F) == PAT_FLTR)      st = ST_FAULT;
    else if ((sw & MASK_4F) == PAT_NRTSO)     st = ST_NOT_READY;
    else                                      st = ST_OTHER;
    return st;
  endfunction

  // Pick the control word for a state
  function automatic logic [7:0] command_for(input drive_state_e st, input logic toggle);
    logic [7:0] cw;
    unique case (st)
      ST_FAULT:       cw = toggle ? CW_FAULT_RST : CW_NONE;
      ST_DISABLED:    cw = CW_SHUTDOWN;
      ST_READY:       cw = CW_SWITCH_ON;
      ST_SWITCHED_ON: cw = CW_ENABLE_OP;
      ST_ENABLED:     cw = CW_ENABLE_OP;
      default:        cw = CW_NONE;
    endcase
    return cw;
  endfunction

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // One sine table entry, quarter-wave Taylor series in Q30, evaluated at elaboration
  function automatic logic signed [31:0] sine_entry(input int unsigned i,
                                                    input int unsigned abits,
                                                    input int unsigned fbits);
    int unsigned qbits;
    int unsigned qsize;
    int unsigned quad;
    int unsigned r;
    int unsigned k;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    logic [31:0] v;
    qbits = abits - 2;
    qsize = 1 << qbits;
    quad  = (i >> qbits) & 3;
    r     = i & (qsize - 1);
    k     = ((quad & 1) != 0) ? (qsize - r) : r;
    x     = (HALF_PI_Q30 * 64'(k)) >> qbits;
    x2    = (x * x) >> 30;
    term  = Q30_ONE;
    term  = Q30_ONE - ((x2 * term) >> 30) / 64'd156;
    term  = Q30_ONE - ((x2 * term) >> 30) / 64'd110;
    term  = Q30_ONE - ((x2 * term) >> 30) / 64'd72;
    term  = Q30_ONE - ((x2 * term) >> 30) / 64'd42;
    term  = Q30_ONE - ((x2 * term) >> 30) / 64'd20;
    term  = Q30_ONE - ((x2 * term) >> 30) / 64'd6;
    s     = (x * term) >> 30;
    v     = 32'((s + (64'd1 << (29 - fbits))) >> (30 - fbits));
    if (k == 0) v = '0;
    if (k == qsize) v = 32'd1 << fbits;
    return ((quad & 2) != 0) ? -$signed(v) : $signed(v);
  endfunction

endpackage

[rtl/ciaes_fifo.sv]
// Small first-in first-out queue that decouples the front from the back.
module ciaes_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Store a transfer at the write pointer
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

[rtl/ciaes_front.sv]
// Front: accepts control cycles, decodes the drive state and advances the time base.
module ciaes_front #(
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic                         q_full_i,
  input  logic [15:0]                  status_word_i,
  input  logic signed [31:0]           actual_position_i,
  input  logic [ciaes_pkg::HOLD_W-1:0] hold_cycles_i,
  input  logic [ciaes_pkg::STEP_W-1:0] phase_step_i,
  output logic                         q_push_o,
  output ciaes_pkg::item_t             q_item_o,
  output logic [TABLE_ADDR_BITS-1:0]   q_idx_o
);

  import ciaes_pkg::*;

  logic              toggle_q, toggle_d;
  logic              seen_q, seen_d;
  logic [31:0]       zero_q, zero_d;
  logic [HOLD_W-1:0] hold_cnt_q, hold_cnt_d;
  logic [31:0]       phase_q, phase_d;

  logic         accept;
  drive_state_e st;
  logic         en_now;
  logic         holding;
  logic [31:0]  zero_eff;

  assign accept = push_i & ~q_full_i;

  // Classify the item
  always_comb begin
    st       = decode_state(status_word_i);
    en_now   = (st == ST_ENABLED);
    holding  = (hold_cnt_q < hold_cycles_i);
    zero_eff = (en_now && !seen_q) ? $unsigned(actual_position_i) : zero_q;

    q_push_o          = accept;
    q_item_o.cw       = command_for(st, toggle_q);
    q_item_o.st       = st;
    q_item_o.base     = en_now ? zero_eff : $unsigned(actual_position_i);
    q_item_o.use_sine = en_now & ~holding;
    q_idx_o           = phase_q[31 -: TABLE_ADDR_BITS];
  end

  // Next state: toggle on every accepted item, capture zero once, then dwell or advance phase
  always_comb begin
    toggle_d   = ~toggle_q;
    seen_d     = seen_q | en_now;
    zero_d     = zero_eff;
    hold_cnt_d = hold_cnt_q;
    phase_d    = phase_q;
    if (seen_d) begin
      if (holding) begin
        hold_cnt_d = hold_cnt_q + HOLD_W'(1);
      end else begin
        phase_d = phase_q + phase_step_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      toggle_q   <= 1'b1;
      seen_q     <= 1'b0;
      zero_q     <= '0;
      hold_cnt_q <= '0;
      phase_q    <= '0;
    end else if (accept) begin
      toggle_q   <= toggle_d;
      seen_q     <= seen_d;
      zero_q     <= zero_d;
      hold_cnt_q <= hold_cnt_d;
      phase_q    <= phase_d;
    end
  end

endmodule

[rtl/ciaes_back.sv]
// Back: sine table lookup, amplitude multiply and target sum in a three-stage pipeline.
module ciaes_back #(
  parameter int unsigned TABLE_ADDR_BITS    = 10,
  parameter int unsigned SINE_FRACTION_BITS = 15
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ciaes_pkg::AMP_W-1:0]   amplitude_i,
  input  logic                          q_empty_i,
  input  ciaes_pkg::item_t              q_item_i,
  input  logic [TABLE_ADDR_BITS-1:0]    q_idx_i,
  output logic                          q_pop_o,
  input  logic                          pop_i,
  output logic                          empty_o,
  output logic [7:0]                    control_word_o,
  output logic signed [31:0]            target_position_o,
  output logic [2:0]                    drive_state_o
);

  import ciaes_pkg::*;

  localparam int unsigned TAB  = 1 << TABLE_ADDR_BITS;
  localparam int unsigned SW   = SINE_FRACTION_BITS + 2;
  localparam int unsigned PW   = SW + AMP_W + 1;

  typedef logic signed [SW-1:0] rom_t [TAB];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < TAB; i++) begin
      r[i] = SW'(sine_entry(i, TABLE_ADDR_BITS, SINE_FRACTION_BITS));
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic                 s1_v_q, s2_v_q, s3_v_q;
  logic                 s1_rdy, s2_rdy, s3_rdy;
  item_t                s1_item_q, s2_item_q;
  logic signed [SW-1:0] rom_q;
  logic signed [PW-1:0] prod_q;
  logic [7:0]           cw_q;
  drive_state_e         st_q;
  logic [31:0]          target_q, target_d;

  logic        neg;
  logic [PW-1:0] mag;
  logic [31:0] delta_mag, delta;

  // Stall chain from the result side back to the queue
  assign s3_rdy  = ~s3_v_q | pop_i;
  assign s2_rdy  = ~s2_v_q | s3_rdy;
  assign s1_rdy  = ~s1_v_q | s2_rdy;
  assign q_pop_o = ~q_empty_i & s1_rdy;

  // Truncate the product toward zero and add it to the base when the sine is in use
  always_comb begin
    neg       = prod_q[PW-1];
    mag       = neg ? $unsigned(-prod_q) : $unsigned(prod_q);
    delta_mag = 32'(mag >> SINE_FRACTION_BITS);
    delta     = neg ? (32'd0 - delta_mag) : delta_mag;
    target_d  = s2_item_q.use_sine ? (s2_item_q.base + delta) : s2_item_q.base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= q_pop_o;
      if (s2_rdy) s2_v_q <= s1_v_q;
      if (s3_rdy) s3_v_q <= s2_v_q;
    end
  end

  // Table read, multiply, sum
  always_ff @(posedge clk_i) begin
    if (s1_rdy && q_pop_o) begin
      s1_item_q <= q_item_i;
      rom_q     <= SINE_ROM[q_idx_i];
    end
    if (s2_rdy && s1_v_q) begin
      s2_item_q <= s1_item_q;
      prod_q    <= PW'($signed({1'b0, amplitude_i})) * PW'(rom_q);
    end
    if (s3_rdy && s2_v_q) begin
      cw_q     <= s2_item_q.cw;
      st_q     <= s2_item_q.st;
      target_q <= target_d;
    end
  end

  assign empty_o           = ~s3_v_q;
  assign control_word_o    = cw_q;
  assign target_position_o = $signed(target_q);
  assign drive_state_o     = st_q;

endmodule

[rtl/cia402_enable_and_sine_trajectory.sv]
// Top level: configuration registers, front, queue and back of the CiA 402 sine sequencer.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+---------------------------------------------------
//  input    | push / full           | status_word_i, actual_position_i
//  result   | empty / pop           | control_word_o, target_position_o, mode_out_o,
//           |                       | drive_state_o
//  config   | psel/penable/pwrite   | paddr (reg i at 4*i), pwdata, prdata, pready
//
//  One control cycle is accepted per clock while full is low; its result passes through
//  the queue, the table read register, the product register and the output register.
//  Throughput is one item per cycle unless pop stalls, set by the single multiplier stage.
//  full rises when the two-entry queue fills while the result side is stalled.
//  Reset: all counters, the time base and the fault reset toggle (high) clear at once.
module cia402_enable_and_sine_trajectory #(
  parameter int unsigned TABLE_ADDR_BITS    = ciaes_pkg::DEF_TABLE_ADDR_BITS,
  parameter int unsigned SINE_FRACTION_BITS = ciaes_pkg::DEF_SINE_FRACTION_BITS,
  parameter int unsigned QUEUE_DEPTH        = ciaes_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [15:0]                  status_word_i,
  input  logic signed [31:0]           actual_position_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [7:0]                   control_word_o,
  output logic signed [31:0]           target_position_o,
  output logic signed [7:0]            mode_out_o,
  output logic [2:0]                   drive_state_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ciaes_pkg::ADDR_W-1:0] paddr,
  input  logic [ciaes_pkg::DATA_W-1:0] pwdata,
  output logic [ciaes_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);

  import ciaes_pkg::*;

  localparam int unsigned QW = $bits(item_t) + TABLE_ADDR_BITS;

  logic [AMP_W-1:0]         amp_q;
  logic [HOLD_W-1:0]        hold_q;
  logic [STEP_W-1:0]        step_q;
  logic signed [MODE_W-1:0] mode_q;

  logic                       cfg_wr;
  reg_idx_e                   reg_idx;
  logic                       q_push, q_full, q_pop, q_empty;
  item_t                      f_item, b_item;
  logic [TABLE_ADDR_BITS-1:0] f_idx, b_idx;
  logic [QW-1:0]              q_rdata;

  // Configuration writes
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q  <= AMP_RESET;
      hold_q <= HOLD_RESET;
      step_q <= STEP_RESET;
      mode_q <= MODE_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_AMPLITUDE: amp_q  <= pwdata[AMP_W-1:0];
        REG_HOLD:      hold_q <= pwdata[HOLD_W-1:0];
        REG_STEP:      step_q <= pwdata[STEP_W-1:0];
        REG_MODE:      mode_q <= $signed(pwdata[MODE_W-1:0]);
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      REG_AMPLITUDE: prdata = DATA_W'(amp_q);
      REG_HOLD:      prdata = DATA_W'(hold_q);
      REG_STEP:      prdata = DATA_W'(step_q);
      REG_MODE:      prdata = DATA_W'($unsigned(mode_q));
    endcase
  end

  ciaes_front #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .q_full_i          (q_full),
    .status_word_i     (status_word_i),
    .actual_position_i (actual_position_i),
    .hold_cycles_i     (hold_q),
    .phase_step_i      (step_q),
    .q_push_o          (q_push),
    .q_item_o          (f_item),
    .q_idx_o           (f_idx)
  );

  ciaes_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({f_item, f_idx}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign b_item = item_t'(q_rdata[QW-1:TABLE_ADDR_BITS]);
  assign b_idx  = q_rdata[TABLE_ADDR_BITS-1:0];

  ciaes_back #(
    .TABLE_ADDR_BITS    (TABLE_ADDR_BITS),
    .SINE_FRACTION_BITS (SINE_FRACTION_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .amplitude_i       (amp_q),
    .q_empty_i         (q_empty),
    .q_item_i          (b_item),
    .q_idx_i           (b_idx),
    .q_pop_o           (q_pop),
    .pop_i             (pop),
    .empty_o           (empty),
    .control_word_o    (control_word_o),
    .target_position_o (target_position_o),
    .drive_state_o     (drive_state_o)
  );

  assign full       = q_full;
  assign mode_out_o = mode_q;

  // Enabled state always commands enable operation
  a_enabled_cw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && drive_state_o == ST_ENABLED) |-> (control_word_o == CW_ENABLE_OP))
    else $error("enabled result without enable-operation control word");

  // Fault state only sends the reset pulse or nothing
  a_fault_cw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && drive_state_o == ST_FAULT) |->
      (control_word_o == CW_FAULT_RST || control_word_o == CW_NONE))
    else $error("fault result with wrong control word");

  // Fault reset pulse only appears in fault
  a_pulse_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && control_word_o == CW_FAULT_RST) |-> (drive_state_o == ST_FAULT))
    else $error("fault reset pulse outside fault");

  // Queue cannot be full and empty together
  a_queue_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_full && q_empty))
    else $error("queue reports full and empty");

endmodule
